FILE: sv/mlrq_pkg.sv
// Shared types, constants and state codes for the multilevel ready queue scheduler.
package mlrq_pkg;

    localparam int TASK_SLOTS = 64;
    localparam int LEVELS     = 5;
    localparam int SLOT_W     = $clog2(TASK_SLOTS);
    localparam int LVL_W      = $clog2(LEVELS);
    localparam int LEN_W      = $clog2(TASK_SLOTS + 1);
    localparam int SCAN_W     = $clog2(2 * LEVELS + 1);

    typedef enum logic [1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_REMOVE  = 2'd1,
        ACT_SELECT  = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0] action;
        logic [5:0] task_index;
        logic [2:0] priority_req;
    } in_item_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] chosen_task;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ENQ,
        ST_REM_LOOK,
        ST_REM_HEAD,
        ST_REM_WALK,
        ST_REM_FIX,
        ST_SEL_SCAN,
        ST_SEL_POP,
        ST_SEL_FIN,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_ENQ,
        CMD_REM_LOOK,
        CMD_REM_HEAD,
        CMD_REM_START,
        CMD_REM_STEP,
        CMD_REM_FIX,
        CMD_SEL_STEP,
        CMD_SEL_POP,
        CMD_SEL_FIN,
        CMD_FAIL
    } cmd_t;

    typedef struct packed {
        logic     item_ok;
        action_t  act;
        logic     is_head;
        logic     walk_hit;
        logic     walk_end;
        logic     sel_hit;
        logic     scan_end;
    } dp_status_t;

endpackage

FILE: sv/mlrq_ctrl.sv
// Controller state machine sequencing enqueue, remove and select operations.
module mlrq_ctrl
    import mlrq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       out_free,
    input  dp_status_t status,
    output cmd_t       cmd,
    output logic       busy,
    output logic       finish
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        busy       = 1'b1;
        finish     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd        = CMD_LATCH;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (!status.item_ok)
                begin
                    cmd        = CMD_FAIL;
                    state_next = ST_DONE;
                end
                else
                begin
                    priority case (status.act)
                        ACT_ENQUEUE: state_next = ST_ENQ;
                        ACT_REMOVE:  state_next = ST_REM_LOOK;
                        default:     state_next = ST_SEL_SCAN;
                    endcase
                end
            end
            ST_ENQ:
            begin
                cmd        = CMD_ENQ;
                state_next = ST_DONE;
            end
            ST_REM_LOOK:
            begin
                cmd        = CMD_REM_LOOK;
                state_next = ST_REM_HEAD;
            end
            ST_REM_HEAD:
            begin
                if (status.is_head)
                begin
                    cmd        = CMD_REM_HEAD;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd        = CMD_REM_START;
                    state_next = ST_REM_WALK;
                end
            end
            ST_REM_WALK:
            begin
                if (status.walk_hit)
                begin
                    state_next = ST_REM_FIX;
                end
                else if (status.walk_end)
                begin
                    cmd        = CMD_REM_FIX;
                    state_next = ST_DONE;
                end
                else
                    cmd = CMD_REM_STEP;
            end
            ST_REM_FIX:
            begin
                cmd        = CMD_REM_FIX;
                state_next = ST_DONE;
            end
            ST_SEL_SCAN:
            begin
                if (status.sel_hit)
                begin
                    cmd        = CMD_SEL_POP;
                    state_next = ST_SEL_POP;
                end
                else if (status.scan_end)
                begin
                    cmd        = CMD_FAIL;
                    state_next = ST_DONE;
                end
                else
                    cmd = CMD_SEL_STEP;
            end
            ST_SEL_POP:
            begin
                state_next = ST_SEL_FIN;
            end
            ST_SEL_FIN:
            begin
                cmd        = CMD_SEL_FIN;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_fin_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> state_reg == ST_DONE)
        else $error("finish outside done state");
    a_done_reached: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ENQ) |=> state_reg == ST_DONE)
        else $error("enqueue did not complete");
    a_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start) |=> state_reg == ST_DECODE)
        else $error("start not taken");

endmodule

FILE: sv/mlrq_dp.sv
// Datapath: slot link memories, per-level queue registers and result register.
module mlrq_dp
    import mlrq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   in_item,
    input  cmd_t       cmd,
    output dp_status_t status,
    output out_item_t  result
);

    logic [SLOT_W-1:0] next_link_mem [TASK_SLOTS];
    logic [LVL_W-1:0]  slot_level_mem [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] queued_reg;

    logic [SLOT_W-1:0] head_reg [LEVELS];
    logic [SLOT_W-1:0] tail_reg [LEVELS];
    logic [LEN_W-1:0]  len_reg [LEVELS];
    logic [LEN_W-1:0]  served_reg [LEVELS];

    action_t           act_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [2:0]        prio_reg;
    logic [LVL_W-1:0]  lvl_reg;
    logic [SLOT_W-1:0] prev_reg;
    logic [SLOT_W-1:0] link_rd_reg;
    logic [SLOT_W-1:0] walk_rd_reg;
    logic [LVL_W-1:0]  lvlmem_rd_reg;
    logic [LEN_W-1:0]  step_reg;
    logic [SCAN_W-1:0] scan_reg;
    logic [LVL_W-1:0]  scan_lvl;
    out_item_t         result_reg;

    logic [LVL_W-1:0]  rem_lvl;
    logic [SLOT_W-1:0] walk_addr;
    logic              scan_wrap;

    assign rem_lvl   = lvlmem_rd_reg;
    assign walk_addr = (cmd == CMD_REM_START) ? head_reg[rem_lvl] : walk_rd_reg;
    assign scan_wrap = (scan_reg >= SCAN_W'(LEVELS));
    assign scan_lvl  = scan_wrap ? LVL_W'(scan_reg - SCAN_W'(LEVELS)) : LVL_W'(scan_reg);

    always_comb
    begin
        status.act = act_reg;
        unique case (act_reg)
            ACT_ENQUEUE: status.item_ok = (32'(prio_reg) < LEVELS) && !queued_reg[slot_reg];
            ACT_REMOVE:  status.item_ok = queued_reg[slot_reg];
            ACT_SELECT:  status.item_ok = 1'b1;
            default:     status.item_ok = 1'b0;
        endcase
        status.is_head  = (head_reg[rem_lvl] == slot_reg);
        status.walk_hit = (walk_rd_reg == slot_reg);
        status.walk_end = (step_reg >= len_reg[rem_lvl]);
        status.sel_hit  = (served_reg[scan_lvl] < len_reg[scan_lvl]);
        status.scan_end = (scan_reg == SCAN_W'(2 * LEVELS - 1));
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd)
            CMD_ENQ:
            begin
                if (len_reg[lvl_reg] != '0)
                    next_link_mem[tail_reg[lvl_reg]] <= slot_reg;
                slot_level_mem[slot_reg] <= lvl_reg;
            end
            CMD_REM_FIX:
            begin
                if (status.walk_hit && !status.walk_end && tail_reg[rem_lvl] != slot_reg)
                    next_link_mem[prev_reg] <= link_rd_reg;
            end
            default:
            begin
            end
        endcase
        if (cmd == CMD_REM_LOOK)
            lvlmem_rd_reg <= slot_level_mem[slot_reg];
        if (cmd == CMD_REM_START || cmd == CMD_REM_STEP)
            walk_rd_reg <= next_link_mem[walk_addr];
        link_rd_reg <= next_link_mem[(cmd == CMD_SEL_POP) ? head_reg[scan_lvl] : slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queued_reg <= '0;
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]   <= '0;
                tail_reg[i]   <= '0;
                len_reg[i]    <= '0;
                served_reg[i] <= '0;
            end
            act_reg    <= ACT_NONE;
            slot_reg   <= '0;
            prio_reg   <= '0;
            lvl_reg    <= '0;
            prev_reg   <= '0;
            step_reg   <= '0;
            scan_reg   <= '0;
            result_reg <= '0;
        end
        else
        begin
            unique case (cmd)
                CMD_LATCH:
                begin
                    act_reg  <= action_t'(in_item.action);
                    slot_reg <= in_item.task_index;
                    prio_reg <= in_item.priority_req;
                    lvl_reg  <= LVL_W'(in_item.priority_req);
                    scan_reg <= '0;
                    step_reg <= LEN_W'(1);
                end
                CMD_FAIL:
                begin
                    result_reg <= '0;
                    if (act_reg == ACT_SELECT)
                        served_reg[scan_lvl] <= '0;
                end
                CMD_ENQ:
                begin
                    if (len_reg[lvl_reg] == '0)
                        head_reg[lvl_reg] <= slot_reg;
                    tail_reg[lvl_reg]    <= slot_reg;
                    len_reg[lvl_reg]     <= len_reg[lvl_reg] + LEN_W'(1);
                    queued_reg[slot_reg] <= 1'b1;
                    result_reg           <= '{ok: 1'b1, chosen_task: '0};
                end
                CMD_REM_LOOK:
                begin
                end
                CMD_REM_HEAD:
                begin
                    if (len_reg[rem_lvl] > LEN_W'(1))
                    begin
                        head_reg[rem_lvl] <= link_rd_reg;
                        len_reg[rem_lvl]  <= len_reg[rem_lvl] - LEN_W'(1);
                    end
                    else
                    begin
                        head_reg[rem_lvl] <= '0;
                        tail_reg[rem_lvl] <= '0;
                        len_reg[rem_lvl]  <= '0;
                    end
                    queued_reg[slot_reg] <= 1'b0;
                    result_reg           <= '{ok: 1'b1, chosen_task: slot_reg};
                end
                CMD_REM_START:
                begin
                    prev_reg <= head_reg[rem_lvl];
                end
                CMD_REM_STEP:
                begin
                    prev_reg <= walk_rd_reg;
                    step_reg <= step_reg + LEN_W'(1);
                end
                CMD_REM_FIX:
                begin
                    if (status.walk_hit && !status.walk_end)
                    begin
                        if (len_reg[rem_lvl] == LEN_W'(1))
                        begin
                            head_reg[rem_lvl] <= '0;
                            tail_reg[rem_lvl] <= '0;
                        end
                        else if (tail_reg[rem_lvl] == slot_reg)
                            tail_reg[rem_lvl] <= prev_reg;
                        len_reg[rem_lvl] <= len_reg[rem_lvl] - LEN_W'(1);
                    end
                    else if (len_reg[rem_lvl] == '0)
                    begin
                        head_reg[rem_lvl] <= '0;
                        tail_reg[rem_lvl] <= '0;
                    end
                    queued_reg[slot_reg] <= 1'b0;
                    result_reg           <= '{ok: 1'b1, chosen_task: slot_reg};
                end
                CMD_SEL_STEP:
                begin
                    served_reg[scan_lvl] <= '0;
                    scan_reg             <= scan_reg + SCAN_W'(1);
                end
                CMD_SEL_POP:
                begin
                    lvl_reg  <= scan_lvl;
                    slot_reg <= head_reg[scan_lvl];
                end
                CMD_SEL_FIN:
                begin
                    if (len_reg[lvl_reg] == LEN_W'(1))
                    begin
                        head_reg[lvl_reg] <= '0;
                        tail_reg[lvl_reg] <= '0;
                    end
                    else
                        head_reg[lvl_reg] <= link_rd_reg;
                    len_reg[lvl_reg]     <= len_reg[lvl_reg] - LEN_W'(1);
                    served_reg[lvl_reg]  <= served_reg[lvl_reg] + LEN_W'(1);
                    queued_reg[slot_reg] <= 1'b0;
                    result_reg           <= '{ok: 1'b1, chosen_task: slot_reg};
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result = result_reg;

    a_enq_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_ENQ) |=> queued_reg[$past(slot_reg)])
        else $error("enqueued slot not marked");
    a_sel_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_SEL_FIN) |=> !queued_reg[$past(slot_reg)] && result_reg.ok)
        else $error("selected slot still queued");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg <= SCAN_W'(2 * LEVELS - 1))
        else $error("scan index past second sweep");

endmodule

FILE: sv/multilevel_ready_queue_scheduler.sv
// Top level of the multilevel ready queue scheduler.
// Usage:
//   in channel  (in_valid/in_ready/in_data): one operation per transfer:
//     enqueue a slot at a level, remove a queued slot, or select the next slot.
//   out channel (out_valid/out_ready/out_data): exactly one result per operation,
//     ok and the removed or selected slot.
// Throughput: one operation at a time. Remove walks the level's linked list one
// link per cycle; select scans one level per cycle over at most two sweeps. A new
// transfer can be taken in the cycle after the result leaves the output register.
// Reset: asynchronous, all queues empty and all served counts zero; link and
// level memories are not cleared and need no clearing pass.
// Stall: while out_ready is low the result is held in the output register and
// the next operation waits in its transfer until the result is taken.
module multilevel_ready_queue_scheduler
    import mlrq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    cmd_t       cmd;
    dp_status_t status;
    logic       busy;
    logic       finish;
    logic       pend_reg;
    logic       pend_next;
    out_item_t  dp_result;

    mlrq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_valid && in_ready),
        .out_free (!pend_reg),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy),
        .finish   (finish)
    );

    mlrq_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_data),
        .cmd     (cmd),
        .status  (status),
        .result  (dp_result)
    );

    always_comb
    begin
        pend_next = pend_reg;
        if (out_valid && out_ready)
            pend_next = 1'b0;
        if (finish)
            pend_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else
            pend_reg <= pend_next;
    end

    assign in_ready  = !busy && !pend_reg;
    assign out_valid = pend_reg;
    assign out_data  = dp_result;

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_data))
        else $error("pending result lost");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transfer while operation in flight");

endmodule

FILE: sim/multilevel_ready_queue_scheduler_test.sv
// Testbench for the multilevel ready queue scheduler: directed and random operations.
module multilevel_ready_queue_scheduler_test;
    import mlrq_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    multilevel_ready_queue_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    logic [5:0] link_mem [TASK_SLOTS];
    logic [2:0] level_of [TASK_SLOTS];
    logic       queued   [TASK_SLOTS];
    logic [5:0] head_q   [LEVELS];
    logic [5:0] tail_q   [LEVELS];
    int         len_q    [LEVELS];
    int         served_q [LEVELS];

    out_item_t  pending_results[$];
    int         failures;
    int         cycle_count;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         hold_off;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic out_item_t schedule_op(in_item_t it);
        out_item_t r;
        int        lv;
        int        s;
        int        prev;
        bit        found;
        r = '0;
        s = int'(it.task_index);
        if (it.action == ACT_ENQUEUE)
        begin
            lv = int'(it.priority_req);
            if (lv < LEVELS && !queued[s])
            begin
                if (len_q[lv] == 0)
                    head_q[lv] = 6'(s);
                else
                    link_mem[tail_q[lv]] = 6'(s);
                tail_q[lv] = 6'(s);
                len_q[lv]++;
                level_of[s] = 3'(lv);
                queued[s] = 1'b1;
                r.ok = 1'b1;
            end
        end
        else if (it.action == ACT_REMOVE)
        begin
            if (queued[s])
            begin
                lv = int'(level_of[s]);
                found = 0;
                if (head_q[lv] == s)
                begin
                    if (len_q[lv] > 1)
                        head_q[lv] = link_mem[s];
                    found = 1;
                end
                else
                begin
                    prev = int'(head_q[lv]);
                    for (int k = 1; k < len_q[lv]; k++)
                    begin
                        if (link_mem[prev] == s)
                        begin
                            if (tail_q[lv] == s)
                                tail_q[lv] = 6'(prev);
                            else
                                link_mem[prev] = link_mem[s];
                            found = 1;
                            break;
                        end
                        prev = int'(link_mem[prev]);
                    end
                end
                if (found && len_q[lv] > 0)
                    len_q[lv]--;
                if (len_q[lv] == 0)
                begin
                    head_q[lv] = '0;
                    tail_q[lv] = '0;
                end
                queued[s] = 1'b0;
                r.ok = 1'b1;
                r.chosen_task = 6'(s);
            end
        end
        else if (it.action == ACT_SELECT)
        begin
            for (int sw = 0; sw < 2 && !r.ok; sw++)
            begin
                for (lv = 0; lv < LEVELS; lv++)
                begin
                    if (served_q[lv] < len_q[lv])
                    begin
                        s = int'(head_q[lv]);
                        len_q[lv]--;
                        if (len_q[lv] == 0)
                        begin
                            head_q[lv] = '0;
                            tail_q[lv] = '0;
                        end
                        else
                            head_q[lv] = link_mem[s];
                        queued[s] = 1'b0;
                        served_q[lv]++;
                        r.ok = 1'b1;
                        r.chosen_task = 6'(s);
                        break;
                    end
                    served_q[lv] = 0;
                end
            end
        end
        return r;
    endfunction

    task automatic send_op(input logic [1:0] act, input int slot, input int lvl);
        in_item_t it;
        it.action = act;
        it.task_index = slot[5:0];
        it.priority_req = lvl[2:0];
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(schedule_op(it));
    endtask

    initial
    begin
        out_item_t exp_r;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result ok=%0d chosen_task=%0d",
                           out_data.ok, out_data.chosen_task);
                    failures++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (out_data.ok !== exp_r.ok)
                    begin
                        $error("ok expected %0d actual %0d", exp_r.ok, out_data.ok);
                        failures++;
                    end
                    if (out_data.chosen_task !== exp_r.chosen_task)
                    begin
                        $error("chosen_task expected %0d actual %0d",
                               exp_r.chosen_task, out_data.chosen_task);
                        failures++;
                    end
                end
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                hold_off--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic test_directed();
        send_op(ACT_SELECT, 0, 0);
        send_op(ACT_REMOVE, 63, 0);
        send_op(ACT_ENQUEUE, 0, 0);
        send_op(ACT_ENQUEUE, 63, 4);
        send_op(ACT_ENQUEUE, 5, 5);
        send_op(ACT_ENQUEUE, 6, 7);
        send_op(ACT_ENQUEUE, 0, 2);
        send_op(ACT_NONE, 63, 7);
        send_op(ACT_ENQUEUE, 10, 0);
        send_op(ACT_ENQUEUE, 11, 0);
        send_op(ACT_ENQUEUE, 12, 0);
        send_op(ACT_REMOVE, 11, 0);
        send_op(ACT_REMOVE, 12, 0);
        send_op(ACT_REMOVE, 11, 0);
        send_op(ACT_ENQUEUE, 11, 3);
        for (int i = 0; i < 7; i++)
            send_op(ACT_SELECT, 42, 7);
        send_op(ACT_REMOVE, 0, 0);
    endtask

    task automatic test_random(input int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 45)
                send_op(ACT_ENQUEUE, $urandom_range(63),
                        ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(4));
            else if (r < 65)
                send_op(ACT_REMOVE, $urandom_range(63), $urandom_range(7));
            else if (r < 97)
                send_op(ACT_SELECT, $urandom_range(63), $urandom_range(7));
            else
                send_op(ACT_NONE, $urandom_range(63), $urandom_range(7));
        end
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        send_idle_pct = 0;
        test_random(20);
        wait_drained();
    endtask

    initial
    begin
        failures = 0;
        hold_off = 0;
        send_idle_pct = 22;
        recv_idle_pct = 56;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        for (int i = 0; i < TASK_SLOTS; i++)
            queued[i] = 1'b0;
        for (int i = 0; i < LEVELS; i++)
        begin
            head_q[i] = '0;
            tail_q[i] = '0;
            len_q[i] = 0;
            served_q[i] = 0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        wait_drained();
        test_random(350);
        wait_drained();
        send_idle_pct = 56;
        recv_idle_pct = 22;
        test_random(300);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(330);
        wait_drained();
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
